// ===== rtl/core/jcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jcb_pkg: shared types and constants of the comment blanker
// Byte codes, lexer mode codes and the result bundle passed to the queue.
// ----------------------------------------------------------------------------
package jcb_pkg;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Output queue depth; two slots of headroom cover one released pair.
	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = $clog2(QDepth);

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_SLASH  = 3'd1,
		M_STR    = 3'd2,
		M_ESC    = 3'd3,
		M_LINE   = 3'd4,
		M_BLOCK  = 3'd5,
		M_STAR   = 3'd6
	} mode_t;

	// Results caused by one item: zero, one or two bytes.
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] ch0;
		logic       last0;
		logic [7:0] ch1;
		logic       last1;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/core/jcb_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jcb_lexer: next-mode and result logic
// Classify one byte against the current lexer mode.
// ----------------------------------------------------------------------------
module jcb_lexer (
	input  wire jcb_pkg::mode_t mode,
	input  wire logic [7:0]     ch,
	input  wire logic           last,
	output jcb_pkg::mode_t      mode_nxt,
	output jcb_pkg::res_t       res
);
	import jcb_pkg::*;

	mode_t      m;
	logic [1:0] n;
	logic [7:0] c0;
	logic [7:0] c1;

	always_comb begin
		m  = mode;
		n  = 2'd0;
		c0 = ch;
		c1 = ch;
		case (mode)
			M_SLASH: begin
				n = 2'd2;
				if (ch == CH_SLASH) begin
					c0 = CH_SPACE;
					c1 = CH_SPACE;
					m  = M_LINE;
				end else if (ch == CH_STAR) begin
					c0 = CH_SPACE;
					c1 = CH_SPACE;
					m  = M_BLOCK;
				end else begin
					c0 = CH_SLASH;
					m  = (ch == CH_QUOTE) ? M_STR : M_NORMAL;
				end
			end
			M_STR: begin
				n = 2'd1;
				if (ch == CH_BSLASH) begin
					m = M_ESC;
				end else if (ch == CH_QUOTE) begin
					m = M_NORMAL;
				end
			end
			M_ESC: begin
				n = 2'd1;
				m = M_STR;
			end
			M_LINE: begin
				n = 2'd1;
				if (ch == CH_NL) begin
					m = M_NORMAL;
				end else begin
					c0 = CH_SPACE;
				end
			end
			M_BLOCK, M_STAR: begin
				n = 2'd1;
				if (ch == CH_NL) begin
					m = M_BLOCK;
				end else begin
					c0 = CH_SPACE;
					if (ch == CH_STAR) begin
						m = M_STAR;
					end else if (ch == CH_SLASH && mode == M_STAR) begin
						m = M_NORMAL;
					end else begin
						m = M_BLOCK;
					end
				end
			end
			default: begin
				// normal text, and the unused code
				if (ch == CH_SLASH && !last) begin
					m = M_SLASH;
				end else begin
					n = 2'd1;
					m = (ch == CH_QUOTE) ? M_STR : M_NORMAL;
				end
			end
		endcase
		if (last) begin
			m = M_NORMAL;
		end
	end

	assign mode_nxt  = m;
	assign res.count = n;
	assign res.ch0   = c0;
	assign res.ch1   = c1;
	assign res.last0 = last && (n == 2'd1);
	assign res.last1 = last && (n == 2'd2);

endmodule
`default_nettype wire

// ===== rtl/core/jcb_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jcb_outq: result queue
// Take up to two results a cycle, hand out one a cycle while not stalled.
// ----------------------------------------------------------------------------
module jcb_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire jcb_pkg::res_t res,
	output logic               room,
	output logic               valid,
	input  wire logic          stall,
	output logic [7:0]         ch,
	output logic               last
);
	import jcb_pkg::*;

	logic [8:0]       mem_q [QDepth];
	logic [QAw-1:0]   wr_q;
	logic [QAw-1:0]   rd_q;
	logic [QAw:0]     cnt_q;
	logic             pop;
	logic [1:0]       nput;
	logic [QAw-1:0]   wr1;

	assign pop   = (cnt_q != '0) && !stall;
	assign nput  = push ? res.count : 2'd0;
	assign wr1   = wr_q + QAw'(1);
	assign room  = cnt_q <= (QAw+1)'(QDepth - 2);
	assign valid = cnt_q != '0;
	assign ch    = mem_q[rd_q][8:1];
	assign last  = mem_q[rd_q][0];

	always_ff @(posedge clk) begin
		if (nput != 2'd0) begin
			mem_q[wr_q] <= {res.ch0, res.last0};
		end
		if (nput == 2'd2) begin
			mem_q[wr1] <= {res.ch1, res.last1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QAw'(nput);
			rd_q  <= rd_q + QAw'(pop);
			cnt_q <= cnt_q + (QAw+1)'(nput) - (QAw+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/jsonc_comment_blanker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsonc_comment_blanker: comment blanker for JSON text with comments
// Replaces comment bytes by spaces, keeps newlines, strings and offsets.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ------------------
//  source   src_valid/src_stall   char_in, last_in
//  result   dst_valid/dst_stall   char_out, last_out
//
// One byte a cycle in and out when nothing stalls. An item is registered
// (stage 1), classified against the lexer mode and its zero to two results
// written to a four-entry queue once the queue has room for two. The source
// stalls only while stage 1 holds an item and the queue lacks room for two
// results. Reset clears the mode to normal text and empties the queue.
//
module jsonc_comment_blanker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] char_in,
	input  wire logic       last_in,
	output logic            dst_valid,
	input  wire logic       dst_stall,
	output logic [7:0]      char_out,
	output logic            last_out
);
	import jcb_pkg::*;

	// Stage 1: the accepted item.
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	mode_t      mode_q;
	mode_t      mode_nxt;
	res_t       res;
	logic       room;
	logic       adv;

	// Advance stage 1 into the queue only when two slots are free.
	assign adv       = vld_s1 && room;
	assign src_stall = vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			mode_q <= M_NORMAL;
		end else begin
			if (!src_stall) begin
				vld_s1 <= src_valid;
			end
			// Advance the lexer mode once per processed item.
			if (adv) begin
				mode_q <= mode_nxt;
			end
		end
	end

	// Payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			ch_s1   <= char_in;
			last_s1 <= last_in;
		end
	end

	jcb_lexer u_lexer (
		.mode     (mode_q),
		.ch       (ch_s1),
		.last     (last_s1),
		.mode_nxt (mode_nxt),
		.res      (res)
	);

	jcb_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv),
		.res    (res),
		.room   (room),
		.valid  (dst_valid),
		.stall  (dst_stall),
		.ch     (char_out),
		.last   (last_out)
	);

endmodule
`default_nettype wire
